/* rtl/core/ivs_pkg.sv */
// ----------------------------------------------------------------------------
// ivs_pkg: shared types and constants for the indexed vector store
// Action and status codes, sequencer states and default depth.
// ----------------------------------------------------------------------------
`default_nettype none

package ivs_pkg;

   localparam int unsigned DefaultDepth = 256;
   localparam int unsigned ActionWidth  = 3;
   localparam int unsigned PosWidth     = 12;
   localparam int unsigned DataWidth    = 64;
   localparam int unsigned StatusWidth  = 2;
   localparam int unsigned FoundWidth   = 8;
   localparam int unsigned CountWidth   = 9;

   typedef enum logic [ActionWidth-1:0] {
      ACT_PUSH   = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_REMOVE = 3'd2,
      ACT_READ   = 3'd3,
      ACT_WRITE  = 3'd4,
      ACT_CLEAR  = 3'd5,
      ACT_LFIND  = 3'd6,
      ACT_BFIND  = 3'd7
   } action_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_FULL    = 2'd2,
      ST_MISSING = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_WR,
      S_REM_RD,
      S_REM_WR,
      S_RD_WAIT,
      S_RD_DONE,
      S_LIN_RD,
      S_LIN_CMP,
      S_BIN_RD,
      S_BIN_CMP,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

/* rtl/core/indexed_vector_store.sv */
// ----------------------------------------------------------------------------
// indexed_vector_store: ordered list of signed 64-bit entries
// Push, insert, remove, read, write, clear, linear and binary search.
// ----------------------------------------------------------------------------
// Usage: raise start with req_action, req_position and req_item_value; the
// request is taken when busy is low. busy stays high until the result has
// been shown. The result appears on the rsp_ ports for one cycle with
// rsp_valid high; the receiver cannot stall and must take it then.
// Each moved or compared entry passes through a read state and then a write or
// compare state; the entry memory has one read port and one write port.
// One request is in flight at a time; a new one is taken in the cycle after
// the result. Reset empties the list at once (count to zero); entry contents
// are left as they are, no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_vector_store
   import ivs_pkg::*;
#(
   parameter int unsigned DEPTH = DefaultDepth
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [ActionWidth-1:0]        req_action,
   input  wire logic [PosWidth-1:0]           req_position,
   input  wire logic signed [DataWidth-1:0]   req_item_value,
   output logic                               rsp_valid,
   output logic [StatusWidth-1:0]             rsp_status,
   output logic signed [DataWidth-1:0]        rsp_read_value,
   output logic [FoundWidth-1:0]              rsp_found_at,
   output logic [CountWidth-1:0]              rsp_entry_count
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   // entry memory
   logic [DataWidth-1:0] mem [DEPTH];
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [DataWidth-1:0] mem_wd;
   logic [AW-1:0]        mem_ra;
   logic [DataWidth-1:0] mem_rd_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // control and payload registers
   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        lo_ff, lo_in;
   logic [CW-1:0]        hi_ff, hi_in;
   logic [CW-1:0]        pos_ff, pos_in;
   logic [DataWidth-1:0] val_ff, val_in;
   logic [StatusWidth-1:0] st_ff, st_in;
   logic [DataWidth-1:0] rd_ff, rd_in;
   logic [CW-1:0]        found_ff, found_in;
   logic                 ins_tail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff   <= idx_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pos_ff   <= pos_in;
      val_ff   <= val_in;
      st_ff    <= st_in;
      rd_ff    <= rd_in;
      found_ff <= found_in;
   end

   // shared compare unit: equality and signed less-than against the key
   logic eq_hit, lt_hit;
   assign eq_hit = (mem_rd_ff == val_ff);
   assign lt_hit = ($signed(mem_rd_ff) < $signed(val_ff));

   logic          in_range;
   logic [CW-1:0] req_pos_cw;
   logic [CW-1:0] mid;
   assign in_range   = ({1'b0, req_position} < (PosWidth+1)'(count_ff));
   assign req_pos_cw = CW'(req_position);
   assign mid        = lo_ff + ((hi_ff - lo_ff) >> 1);

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      st_in    = st_ff;
      rd_in    = rd_ff;
      found_in = found_ff;
      mem_we   = 1'b0;
      mem_wa   = idx_ff[AW-1:0];
      mem_wd   = val_ff;
      mem_ra   = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               val_in   = req_item_value;
               pos_in   = req_pos_cw;
               st_in    = ST_OK;
               rd_in    = '0;
               found_in = '0;
               state_in = S_DONE;
               case (action_type'(req_action))
                  ACT_PUSH, ACT_INSERT: begin
                     if (count_ff >= CW'(DEPTH)) begin
                        st_in = ST_FULL;
                     end else if (req_action == ACT_PUSH || !in_range) begin
                        mem_we   = 1'b1;
                        mem_wa   = count_ff[AW-1:0];
                        mem_wd   = req_item_value;
                        count_in = count_ff + 1'b1;
                     end else begin
                        idx_in   = count_ff;
                        mem_ra   = AW'(count_ff - 1'b1);
                        state_in = S_INS_RD;
                     end
                  end
                  ACT_REMOVE: begin
                     if (!in_range) begin
                        st_in = ST_RANGE;
                     end else begin
                        idx_in   = req_pos_cw;
                        mem_ra   = AW'(req_pos_cw + 1'b1);
                        state_in = S_REM_RD;
                     end
                  end
                  ACT_READ: begin
                     if (!in_range) begin
                        st_in = ST_RANGE;
                     end else begin
                        idx_in   = req_pos_cw;
                        mem_ra   = req_pos_cw[AW-1:0];
                        state_in = S_RD_WAIT;
                     end
                  end
                  ACT_WRITE: begin
                     if (!in_range) begin
                        st_in = ST_RANGE;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = req_pos_cw[AW-1:0];
                        mem_wd = req_item_value;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_LFIND: begin
                     idx_in   = '0;
                     st_in    = ST_MISSING;
                     state_in = S_LIN_RD;
                  end
                  default: begin
                     lo_in    = '0;
                     hi_in    = count_ff;
                     st_in    = ST_MISSING;
                     state_in = S_BIN_RD;
                  end
               endcase
            end
         end
         // insert: move entry idx-1 up to idx, down to pos
         S_INS_RD: begin
            mem_ra   = AW'(idx_ff - 1'b1);
            state_in = S_INS_WR;
         end
         S_INS_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[AW-1:0];
            mem_wd = mem_rd_ff;
            idx_in = idx_ff - 1'b1;
            if (idx_ff - 1'b1 == pos_ff) begin
               state_in = S_DONE;
            end else begin
               mem_ra   = AW'(idx_ff - 2'd2);
               state_in = S_INS_RD;
            end
         end
         // remove: move entry idx+1 down to idx
         S_REM_RD: begin
            mem_ra = AW'(idx_ff + 1'b1);
            if (idx_ff + 1'b1 >= count_ff) begin
               count_in = count_ff - 1'b1;
               state_in = S_DONE;
            end else begin
               state_in = S_REM_WR;
            end
         end
         S_REM_WR: begin
            mem_we   = 1'b1;
            mem_wa   = idx_ff[AW-1:0];
            mem_wd   = mem_rd_ff;
            idx_in   = idx_ff + 1'b1;
            mem_ra   = AW'(idx_ff + 2'd2);
            state_in = S_REM_RD;
         end
         S_RD_WAIT: begin
            state_in = S_RD_DONE;
         end
         S_RD_DONE: begin
            rd_in    = mem_rd_ff;
            state_in = S_DONE;
         end
         // linear find: one read, one compare per entry
         S_LIN_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_LIN_CMP;
            end
         end
         S_LIN_CMP: begin
            if (eq_hit) begin
               st_in    = ST_OK;
               found_in = idx_ff;
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               mem_ra   = AW'(idx_ff + 1'b1);
               state_in = S_LIN_RD;
            end
         end
         // binary search: read midpoint, then narrow
         S_BIN_RD: begin
            mem_ra = mid[AW-1:0];
            idx_in = mid;
            if (lo_ff >= hi_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_BIN_CMP;
            end
         end
         S_BIN_CMP: begin
            if (eq_hit) begin
               st_in    = ST_OK;
               found_in = idx_ff;
               state_in = S_DONE;
            end else if (lt_hit) begin
               lo_in    = idx_ff + 1'b1;
               state_in = S_BIN_RD;
            end else begin
               hi_in    = idx_ff;
               state_in = S_BIN_RD;
            end
         end
         // result cycle; an insert writes its new value at pos here
         S_DONE: begin
            if (ins_tail_ff) begin
               mem_we = 1'b1;
               mem_wa = pos_ff[AW-1:0];
               mem_wd = val_ff;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // insert completes: one more entry
      if (state_ff == S_INS_WR && idx_ff - 1'b1 == pos_ff) begin
         count_in = count_ff + 1'b1;
      end
   end

   // marks the result cycle of an insert that still owes its tail write
   always_ff @(posedge clock) begin
      if (reset) begin
         ins_tail_ff <= 1'b0;
      end else begin
         ins_tail_ff <= (state_ff == S_INS_WR) && (idx_ff - 1'b1 == pos_ff);
      end
   end

   // result outputs
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_DONE);
   assign rsp_status      = st_ff;
   assign rsp_read_value  = rd_ff;
   assign rsp_found_at    = FoundWidth'(found_ff);
   assign rsp_entry_count = CountWidth'(count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count beyond depth");
   a_accept_one: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted without going busy");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result shown twice");
`endif

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for indexed_vector_store
// Drives push/insert/remove/read/write/clear/search requests, predicts each
// response from a behavioural copy of the list and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import ivs_pkg::*;

   localparam int unsigned Depth     = DefaultDepth;
   localparam int unsigned NumItems  = 1950;
   localparam int unsigned IdleLimit = 5000;

   typedef struct {
      status_type               status;
      logic signed [DataWidth-1:0] read_value;
      logic [FoundWidth-1:0]    found_at;
      logic [CountWidth-1:0]    entry_count;
   } response_type;

   // List model and queue of predicted responses
   class list_scoreboard;
      logic signed [DataWidth-1:0] cells [Depth];
      int unsigned                 fill;
      response_type                expected_q [$];
      int unsigned                 mismatches;

      function new();
         fill = 0;
         mismatches = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // Apply an accepted request to the list and queue its response
      function void note_request(action_type act, logic [PosWidth-1:0] pos,
                                 logic signed [DataWidth-1:0] val);
         response_type r;
         int lo, hi, mid;
         r.status = ST_OK;
         r.read_value = '0;
         r.found_at = '0;
         case (act)
            ACT_PUSH, ACT_INSERT: begin
               if (fill >= Depth) begin
                  r.status = ST_FULL;
               end else if (act == ACT_PUSH || pos >= fill) begin
                  cells[fill] = val;
                  fill++;
               end else begin
                  for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
                  cells[pos] = val;
                  fill++;
               end
            end
            ACT_REMOVE: begin
               if (pos >= fill) begin
                  r.status = ST_RANGE;
               end else begin
                  for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            ACT_READ: begin
               if (pos >= fill) r.status = ST_RANGE;
               else r.read_value = cells[pos];
            end
            ACT_WRITE: begin
               if (pos >= fill) r.status = ST_RANGE;
               else cells[pos] = val;
            end
            ACT_CLEAR: fill = 0;
            ACT_LFIND: begin
               r.status = ST_MISSING;
               for (int i = 0; i < fill; i++) begin
                  if (cells[i] == val) begin
                     r.status = ST_OK;
                     r.found_at = i[FoundWidth-1:0];
                     break;
                  end
               end
            end
            default: begin
               // midpoint search over [lo, hi), signed ordering
               r.status = ST_MISSING;
               lo = 0;
               hi = fill;
               while (lo < hi) begin
                  mid = lo + (hi - lo) / 2;
                  if (cells[mid] == val) begin
                     r.status = ST_OK;
                     r.found_at = mid[FoundWidth-1:0];
                     break;
                  end
                  if (cells[mid] < val) lo = mid + 1;
                  else hi = mid;
               end
            end
         endcase
         r.entry_count = fill[CountWidth-1:0];
         expected_q.push_back(r);
      endfunction

      // Compare one response against the oldest prediction
      function void check_response(logic [StatusWidth-1:0] st,
                                   logic signed [DataWidth-1:0] rd,
                                   logic [FoundWidth-1:0] fa,
                                   logic [CountWidth-1:0] cnt);
         response_type e;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: status %0d", st);
            return;
         end
         e = expected_q.pop_front();
         if (st !== e.status || rd !== e.read_value || fa !== e.found_at ||
             cnt !== e.entry_count) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: exp st %0d rd %0d at %0d cnt %0d, ",
                         "got st %0d rd %0d at %0d cnt %0d"},
                        e.status, e.read_value, e.found_at, e.entry_count,
                        st, rd, fa, cnt);
         end
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [ActionWidth-1:0]      req_action = '0;
   logic [PosWidth-1:0]         req_position = '0;
   logic signed [DataWidth-1:0] req_item_value = '0;
   logic                        rsp_valid;
   logic [StatusWidth-1:0]      rsp_status;
   logic signed [DataWidth-1:0] rsp_read_value;
   logic [FoundWidth-1:0]       rsp_found_at;
   logic [CountWidth-1:0]       rsp_entry_count;

   list_scoreboard sb = new();
   int unsigned    sent = 0;
   int unsigned    quiet_cycles = 0;

   indexed_vector_store #(.DEPTH(Depth)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_position(req_position),
      .req_item_value(req_item_value), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_read_value(rsp_read_value),
      .rsp_found_at(rsp_found_at), .rsp_entry_count(rsp_entry_count)
   );

   always #5 clock = ~clock;

   // Monitor: responses checked first, then accepted requests noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_response(rsp_status, rsp_read_value, rsp_found_at, rsp_entry_count);
         if (start && !busy)
            sb.note_request(action_type'(req_action), req_position, req_item_value);
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Present one request and hold it until taken
   task automatic send_request(action_type act, logic [PosWidth-1:0] pos,
                               logic signed [DataWidth-1:0] val);
      start <= 1'b1;
      req_action <= act;
      req_position <= pos;
      req_item_value <= val;
      do @(posedge clock); while (busy);
      sent++;
      // random gaps, none in a long middle stretch
      if ((sent < 700 || sent > 1100) && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic logic signed [DataWidth-1:0] pick_value();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 50) return $signed(64'($urandom_range(0, 15))) - 8;
      if (k < 55) return {1'b1, 63'd0};
      if (k < 60) return {1'b0, {63{1'b1}}};
      return {$urandom, $urandom};
   endfunction

   function automatic logic [PosWidth-1:0] pick_position();
      int unsigned k;
      k = $urandom_range(0, 99);
      if (k < 70) return PosWidth'($urandom_range(0, sb.fill));
      if (k < 90) return PosWidth'(sb.fill + $urandom_range(0, 3));
      return PosWidth'($urandom);
   endfunction

   // Random request; grow mode favours push and insert to reach a full store
   task automatic random_request(bit grow);
      int unsigned k;
      action_type act;
      k = $urandom_range(0, 99);
      if (grow) act = (k < 95) ? action_type'($urandom_range(0, 1))
                               : action_type'($urandom_range(2, 7));
      else if (k < 3) act = ACT_CLEAR;
      else begin
         act = action_type'($urandom_range(0, 7));
         if (act == ACT_CLEAR) act = ACT_READ;
      end
      send_request(act, pick_position(), pick_value());
   endtask

   // Sorted list, then searches for present and absent values
   task automatic sorted_set();
      logic signed [DataWidth-1:0] v;
      logic signed [DataWidth-1:0] vals [40];
      int unsigned n;
      n = $urandom_range(1, 40);
      send_request(ACT_CLEAR, '0, '0);
      v = $signed(64'($urandom_range(0, 1000))) - 500;
      for (int i = 0; i < n; i++) begin
         vals[i] = v;
         send_request(ACT_PUSH, '0, v);
         v = v + $urandom_range(1, 4);
      end
      repeat (12) begin
         if ($urandom_range(0, 1))
            send_request(ACT_BFIND, '0, vals[$urandom_range(0, n - 1)]);
         else
            send_request($urandom_range(0, 3) == 0 ? ACT_LFIND : ACT_BFIND,
                         '0, v - $urandom_range(0, 4 * n + 4));
      end
   endtask

   initial begin
      int wait_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty searches, extremes, insert cases, bad indexes
      send_request(ACT_LFIND, '0, 64'sd5);
      send_request(ACT_BFIND, '0, 64'sd5);
      send_request(ACT_READ, '0, '0);
      send_request(ACT_REMOVE, '0, '0);
      send_request(ACT_PUSH, '0, {1'b1, 63'd0});
      send_request(ACT_PUSH, '0, {1'b0, {63{1'b1}}});
      send_request(ACT_INSERT, 12'd1, 64'sd0);
      send_request(ACT_INSERT, 12'd0, -64'sd1);
      send_request(ACT_INSERT, 12'hFFF, 64'sd7);
      send_request(ACT_READ, 12'd2, '0);
      send_request(ACT_READ, 12'hFFF, '0);
      send_request(ACT_WRITE, 12'd4, 64'sd3);
      send_request(ACT_WRITE, 12'd5, 64'sd3);
      send_request(ACT_LFIND, '0, 64'sd3);
      send_request(ACT_LFIND, '0, 64'sd99);
      send_request(ACT_BFIND, '0, -64'sd1);
      send_request(ACT_BFIND, '0, 64'sd99);
      send_request(ACT_REMOVE, 12'd0, '0);
      send_request(ACT_REMOVE, 12'd3, '0);
      send_request(ACT_REMOVE, 12'd9, '0);
      send_request(ACT_CLEAR, '0, '0);
      send_request(ACT_READ, '0, '0);

      // Random phases: grow to full, mixed traffic, sorted searches
      while (sent < NumItems) begin
         case ((sent / 300) % 3)
            0: random_request(1'b1);
            1: random_request(1'b0);
            default: sorted_set();
         endcase
      end
      start <= 1'b0;
      @(posedge clock);

      wait_cycles = 0;
      while (sb.pending() > 0 && wait_cycles < IdleLimit) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/core/ivs_pkg.sv
rtl/core/indexed_vector_store.sv
tb/tb_top.sv
